@@ rtl/rph_pkg.sv @@
// Shared types, constants and the base-65521 division step for the
// radix-128 password hash unit. No dependencies.
`default_nettype none

package rph_pkg;

  localparam int unsigned ACC_W     = 64;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned DIGIT_W   = 16;
  localparam int unsigned HASH_W    = 16;
  localparam int unsigned CHUNKS    = ACC_W / DIGIT_W;
  localparam int unsigned DIVISIONS = 3;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] MODULUS   = 17'd65521;
  localparam logic [15:0] WEIGHT_D1 = 16'd45912;
  localparam logic [15:0] WEIGHT_D2 = 16'd35511;
  localparam logic [15:0] WEIGHT_D3 = 16'd65169;
  localparam logic [15:0] WEIGHT_D4 = 16'd4625;

  // Password value handed from the front end to the queue.
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] value;
  } push_t;

  // Queue status seen by the front end and the back end.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] q;
    logic [DIGIT_W-1:0] r;
  } divstep_t;

  // One long-division digit: (rem * 2^16 + chunk) / 65521 with rem < 65521.
  // Uses 2^16 = 65521 + 15, folding the high half twice and correcting once.
  function automatic divstep_t div_step(logic [DIGIT_W-1:0] rem,
                                        logic [DIGIT_W-1:0] chunk);
    logic [19:0] r0;
    logic [16:0] r1;
    logic [16:0] qs;
    divstep_t    res;
    r0 = {4'd0, chunk} + 20'(rem) * 20'd15;
    r1 = {1'b0, r0[15:0]} + 17'(r0[19:16]) * 17'd15;
    qs = {1'b0, rem} + 17'(r0[19:16]);
    if (r1 >= MODULUS) begin
      r1 = r1 - MODULUS;
      qs = qs + 17'd1;
    end
    res.q = qs[DIGIT_W-1:0];
    res.r = r1[DIGIT_W-1:0];
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/rph_front.sv @@
// Front end: folds characters into the radix-128 accumulator and pushes
// the finished value into the queue. Depends on rph_pkg.
`default_nettype none

module rph_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [rph_pkg::CHAR_W-1:0]  in_character,
  input  wire logic                        in_last_char,
  input  wire rph_pkg::q_stat_t            q_stat,
  output rph_pkg::push_t                   push
);

  logic [rph_pkg::ACC_W-1:0] acc_r;
  logic [rph_pkg::ACC_W-1:0] acc_nxt;
  logic                      take;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  // The multiply by 128 wraps modulo 2^64, so the top seven bits fall off.
  always_comb begin
    acc_nxt    = {acc_r[rph_pkg::ACC_W-rph_pkg::CHAR_W-1:0], in_character};
    push.valid = take && in_last_char;
    push.value = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (take) begin
      acc_r <= in_last_char ? '0 : acc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/rph_queue.sv @@
// Short register queue that decouples the front end from the reduction
// pipeline. Depends on rph_pkg.
`default_nettype none

module rph_queue #(
  parameter int unsigned DEPTH = rph_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rph_pkg::push_t             push,
  input  wire logic                       pop,
  output logic [rph_pkg::ACC_W-1:0]       rd_data,
  output rph_pkg::q_stat_t                stat
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [rph_pkg::ACC_W-1:0] mem_r [DEPTH];
  logic [IdxW-1:0]           wr_ptr_r;
  logic [IdxW-1:0]           rd_ptr_r;
  logic [CntW-1:0]           cnt_r;
  logic                      do_push;
  logic                      do_pop;

  assign stat.full  = (cnt_r == CntW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push.valid && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == IdxW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == IdxW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/rph_back.sv @@
// Back end: pipelined base-65521 digit extraction, weighted sum and final
// modular reduction, ending in the output register. Depends on rph_pkg.
`default_nettype none

module rph_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire logic [rph_pkg::ACC_W-1:0]    q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rph_pkg::HASH_W-1:0]        out_hash_value
);

  localparam int unsigned DivStages = rph_pkg::CHUNKS * rph_pkg::DIVISIONS;
  localparam int unsigned DW        = rph_pkg::DIGIT_W;
  localparam int unsigned AW        = rph_pkg::ACC_W;

  typedef struct packed {
    logic [AW-1:0] num;
    logic [AW-1:0] quo;
    logic [DW-1:0] rem;
    logic [DW-1:0] d4;
    logic [DW-1:0] d3;
    logic [DW-1:0] d2;
  } div_st_t;

  div_st_t              stage_in  [DivStages];
  div_st_t              stage_nxt [DivStages];
  div_st_t              div_r     [DivStages];
  logic [DivStages-1:0] div_vld_r;

  logic [DW-1:0] d1_r, d2_r, d3_r, d4_r;
  logic          dig_vld_r;
  logic [16:0]   q3;
  logic [16:0]   d1_full;
  logic [31:0]   p1_r, p2_r, p3_r, p4_r;
  logic          prod_vld_r;
  logic [33:0]   sum_r;
  logic          sum_vld_r;
  logic [21:0]   fold_r;
  logic          fold_vld_r;
  logic [16:0]   fold2;
  logic [16:0]   red;
  logic [DW-1:0] hash_r;
  logic          out_valid_r;
  logic          adv;

  // The whole pipeline moves together; it halts only while a result waits.
  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && q_valid;

  assign stage_in[0] = '{num: q_data, quo: '0, rem: '0, d4: '0, d3: '0, d2: '0};

  for (genvar k = 0; k < DivStages; k++) begin : g_div
    localparam int unsigned Step = k % rph_pkg::CHUNKS;
    localparam int unsigned Dv   = k / rph_pkg::CHUNKS;

    logic [AW-1:0]     src_num;
    logic [AW-1:0]     src_quo;
    logic [DW-1:0]     src_rem;
    rph_pkg::divstep_t res;

    if (k > 0) begin : g_link
      assign stage_in[k] = div_r[k-1];
    end

    // Each stage consumes the top 16-bit chunk; a new division starts on the
    // previous quotient with a zero remainder.
    always_comb begin
      src_num = (Step == 0 && Dv > 0) ? stage_in[k].quo : stage_in[k].num;
      src_quo = (Step == 0) ? '0 : stage_in[k].quo;
      src_rem = (Step == 0) ? '0 : stage_in[k].rem;
      res     = rph_pkg::div_step(src_rem, src_num[AW-1:AW-DW]);
      stage_nxt[k]     = stage_in[k];
      stage_nxt[k].num = {src_num[AW-DW-1:0], {DW{1'b0}}};
      stage_nxt[k].quo = {src_quo[AW-DW-1:0], res.q};
      stage_nxt[k].rem = res.r;
      if (Step == rph_pkg::CHUNKS - 1) begin
        if (Dv == 0) begin
          stage_nxt[k].d4 = res.r;
        end else if (Dv == 1) begin
          stage_nxt[k].d3 = res.r;
        end else begin
          stage_nxt[k].d2 = res.r;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k] <= stage_nxt[k];
      end
    end
  end

  // The third quotient stays below twice the modulus.
  assign q3      = div_r[DivStages-1].quo[16:0];
  assign d1_full = (q3 >= rph_pkg::MODULUS) ? q3 - rph_pkg::MODULUS : q3;

  // Second fold leaves a value below twice the modulus.
  always_comb begin
    fold2 = {1'b0, fold_r[15:0]} + 17'(fold_r[21:16]) * 17'd15;
    red   = (fold2 >= rph_pkg::MODULUS) ? fold2 - rph_pkg::MODULUS : fold2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_r   <= d1_full[DW-1:0];
      d2_r   <= div_r[DivStages-1].d2;
      d3_r   <= div_r[DivStages-1].d3;
      d4_r   <= div_r[DivStages-1].d4;
      p1_r   <= 32'(d1_r) * 32'(rph_pkg::WEIGHT_D1);
      p2_r   <= 32'(d2_r) * 32'(rph_pkg::WEIGHT_D2);
      p3_r   <= 32'(d3_r) * 32'(rph_pkg::WEIGHT_D3);
      p4_r   <= 32'(d4_r) * 32'(rph_pkg::WEIGHT_D4);
      sum_r  <= 34'(p1_r) + 34'(p2_r) + 34'(p3_r) + 34'(p4_r);
      fold_r <= {6'd0, sum_r[15:0]} + 22'(sum_r[33:16]) * 22'd15;
      hash_r <= red[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r   <= '0;
      dig_vld_r   <= 1'b0;
      prod_vld_r  <= 1'b0;
      sum_vld_r   <= 1'b0;
      fold_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      div_vld_r   <= {div_vld_r[DivStages-2:0], q_valid};
      dig_vld_r   <= div_vld_r[DivStages-1];
      prod_vld_r  <= dig_vld_r;
      sum_vld_r   <= prod_vld_r;
      fold_vld_r  <= sum_vld_r;
      out_valid_r <= fold_vld_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = hash_r;

endmodule

`default_nettype wire

@@ rtl/radix128_password_hash_unit.sv @@
// Top level of the radix-128 password hash unit: front end, queue and
// reduction back end. Depends on rph_pkg, rph_front, rph_queue, rph_back.
//
// Usage: characters arrive on the in_ channel, one per transfer, first
// character first, with in_last_char set on the final one. Each character
// is folded into a 64-bit accumulator (times 128 plus the character,
// wrapping). The final character hands the value to a short queue and
// clears the accumulator; every password needs at least one character.
// The back end splits the value into four base-65521 digits through
// twelve pipelined 16-bit long-division steps, forms the weighted sum and
// reduces it modulo 65521. The hash leaves on the out_ channel.
// Throughput: one character per cycle while in_ready is high, and one hash per
// cycle when every character ends a password and the receiver does not stall.
// The final character's value passes through the queue and then the
// 17-stage back-end pipeline to out_valid.
// When the receiver stalls the back end holds in place; the queue then
// fills and in_ready drops once it is full. Reset clears the accumulator,
// the queue and all pipeline valid bits.
`default_nettype none

module radix128_password_hash_unit #(
  parameter int unsigned QUEUE_DEPTH = rph_pkg::QUEUE_DEPTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rph_pkg::CHAR_W-1:0]   in_character,
  input  wire logic                         in_last_char,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rph_pkg::HASH_W-1:0]        out_hash_value
);

  rph_pkg::push_t            push;
  rph_pkg::q_stat_t          q_stat;
  logic [rph_pkg::ACC_W-1:0] q_data;
  logic                      q_pop;

  rph_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .q_stat       (q_stat),
    .push         (push)
  );

  rph_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .pop     (q_pop),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  rph_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (!q_stat.empty),
    .q_data         (q_data),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  // A hash is always fully reduced.
  a_hash_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (17'(out_hash_value) < rph_pkg::MODULUS))
    else $error("hash value not reduced below the modulus");

  // Only a transferred final character pushes into the queue.
  a_push_on_last : assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> (in_valid && in_ready && in_last_char && !q_stat.full))
    else $error("queue push without a final character transfer");

  // The back end takes from the queue only when it holds a value.
  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("back end popped an empty queue");

  // A non-final character never produces a queue entry.
  a_no_push_mid : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_last_char) |-> !push.valid)
    else $error("queue push on a non-final character");

endmodule

`default_nettype wire

@@ tb/sv/radix128_password_hash_unit_test.sv @@
// Self-checking testbench for radix128_password_hash_unit: drives passwords
// one character per transfer with random gaps and back-pressure, predicts every hash.
// Depends on rph_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module radix128_password_hash_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_CHARS = 1800;

  // Tracks the radix-128 accumulator and holds the hashes still owed by the unit.
  class hash_scoreboard;
    localparam bit [63:0] MOD = 64'd65521;
    localparam bit [63:0] W1  = 64'd45912;
    localparam bit [63:0] W2  = 64'd35511;
    localparam bit [63:0] W3  = 64'd65169;
    localparam bit [63:0] W4  = 64'd4625;

    bit [63:0]   acc;
    bit [15:0]   owed_hashes[$];
    int unsigned errors;

    function new();
      acc    = '0;
      errors = 0;
    endfunction

    function void note_char(bit [6:0] ch, bit last);
      bit [63:0] v, d1, d2, d3, d4, sum;
      acc = {acc[56:0], 7'd0} + {57'd0, ch};
      if (last) begin
        v   = acc;
        d4  = v % MOD;
        v   = v / MOD;
        d3  = v % MOD;
        v   = v / MOD;
        d2  = v % MOD;
        v   = v / MOD;
        d1  = v % MOD;
        // Each term stays below 2^32, so the sum cannot wrap in 64 bits.
        sum = W1 * d1 + W2 * d2 + W3 * d3 + W4 * d4;
        owed_hashes = {owed_hashes, 16'(sum % MOD)};
        acc = '0;
      end
    endfunction

    function void check_hash(bit [15:0] got);
      bit [15:0] want;
      if (owed_hashes.size() == 0) begin
        $display("%0t: unexpected hash transfer, got %0d, expected none", $time, got);
        errors++;
      end else begin
        want = owed_hashes.pop_front();
        if (got !== want) begin
          $display("%0t: hash mismatch, expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function void check_drained();
      if (owed_hashes.size() != 0) begin
        $display("%0t: %0d hashes never arrived, expected next %0d, got none",
                 $time, owed_hashes.size(), owed_hashes[0]);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic [rph_pkg::CHAR_W-1:0]   in_character;
  logic                         in_last_char;
  logic                         out_valid;
  logic                         out_ready;
  logic [rph_pkg::HASH_W-1:0]   out_hash_value;

  hash_scoreboard sb = new();
  int unsigned    cycle_count;
  bit             in_burst;
  bit             out_burst;

  radix128_password_hash_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_character   (in_character),
    .in_last_char   (in_last_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_hash(out_hash_value);
    end
  end

  // Sends one character; the scoreboard sees it once the transfer happens.
  task automatic send_char(bit [6:0] ch, bit last);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_character <= ch;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(ch, last);
  endtask

  task automatic send_password(int unsigned len);
    bit [6:0] ch;
    int unsigned pick;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        ch = 7'd0;
      end else if (pick == 1) begin
        ch = 7'h7f;
      end else begin
        ch = 7'($urandom_range(0, 127));
      end
      send_char(ch, i == len - 1);
    end
  endtask

  // Result side: random stalls between transfers, with stall-free stretches.
  initial begin
    int unsigned gap;
    int unsigned results_seen;
    out_ready    <= 1'b0;
    results_seen = 0;
    out_burst    = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (results_seen % 32 == 0) begin
        out_burst = ($urandom_range(0, 3) == 0);
      end
      gap = out_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned len;
    in_burst      = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_character <= '0;
    in_last_char <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Shortest passwords at both character extremes.
    send_char(7'd0, 1'b1);
    send_char(7'h7f, 1'b1);
    // Ten all-ones characters overflow 64 bits and leave the accumulator all ones.
    for (int i = 0; i < 10; i++) begin
      send_char(7'h7f, i == 9);
    end
    // An all-zero password hashes to zero.
    for (int i = 0; i < 3; i++) begin
      send_char(7'd0, i == 2);
    end
    send_char(7'h68, 1'b0);
    send_char(7'h65, 1'b0);
    send_char(7'h6c, 1'b0);
    send_char(7'h6c, 1'b0);
    send_char(7'h6f, 1'b1);

    sent = 0;
    while (sent < RANDOM_CHARS) begin
      in_burst = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(10, 24);
      end else begin
        len = $urandom_range(1, 9);
      end
      send_password(len);
      sent += len;
    end
    in_valid <= 1'b0;

    while (sb.owed_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
